>>> rtl/core/irpdt_pkg.sv
package irpdt_pkg;

	// Frame buffer sizing
	localparam int MAX_FRAME_BYTES = 8;
	localparam int PTR_W = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

	// Field widths
	localparam int TICK_W = 16;
	localparam int BYTE_W = 8;
	localparam int BIT_W = 3;
	localparam int CFG_IDX_W = 3;

	// Command queue between the front and back parts
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HDR_MARK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HDR_SPACE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_MARK = 3'd5;

	// Register defaults (10 us ticks)
	localparam logic [TICK_W-1:0] RST_HDR_MARK = 16'd450;
	localparam logic [TICK_W-1:0] RST_HDR_SPACE = 16'd450;
	localparam logic [TICK_W-1:0] RST_BIT_MARK = 16'd53;
	localparam logic [TICK_W-1:0] RST_ZERO_SPACE = 16'd56;
	localparam logic [TICK_W-1:0] RST_ONE_SPACE = 16'd169;
	localparam logic [TICK_W-1:0] RST_STOP_MARK = 16'd56;

	// Input kind codes
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] byte_value;
		logic              last_byte;
	} in_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
		logic load_rejected;
	} out_t;

	// Classified command handed from front to back
	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_LOAD,
		CMD_LOAD_LAST
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [BYTE_W-1:0] byte_value;
	} op_t;

	typedef struct packed {
		logic              valid;
		logic [CFG_IDX_W-1:0] index;
		logic [TICK_W-1:0] data;
	} cfg_wr_t;

endpackage

>>> rtl/core/irpdt_front.sv
module irpdt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  irpdt_pkg::in_t   in_data,
	output logic             q_valid,
	output irpdt_pkg::op_t   q_op,
	input  logic             q_pop
);

	irpdt_pkg::op_t              queue_q [irpdt_pkg::QUEUE_DEPTH];
	logic [irpdt_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [irpdt_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [irpdt_pkg::QCNT_W-1:0] count_q;
	irpdt_pkg::op_t              op_in;
	logic                        push;
	logic                        pop;

	// Classify the incoming beat
	always_comb begin
		op_in.byte_value = in_data.byte_value;
		if (in_data.kind == irpdt_pkg::KIND_TICK) begin
			op_in.cmd = irpdt_pkg::CMD_TICK;
		end else if (in_data.last_byte) begin
			op_in.cmd = irpdt_pkg::CMD_LOAD_LAST;
		end else begin
			op_in.cmd = irpdt_pkg::CMD_LOAD;
		end
	end

	assign in_ready = (count_q != irpdt_pkg::QCNT_W'(irpdt_pkg::QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_op     = queue_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= op_in;
		end
	end

	// Queue pointers, wrapping at the queue depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == irpdt_pkg::QPTR_W'(irpdt_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == irpdt_pkg::QPTR_W'(irpdt_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/irpdt_back.sv
module irpdt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  irpdt_pkg::cfg_wr_t cfg_wr,
	input  logic               q_valid,
	input  irpdt_pkg::op_t     q_op,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output irpdt_pkg::out_t    out_data
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR_MARK,
		PH_HDR_SPACE,
		PH_BIT_MARK,
		PH_BIT_SPACE,
		PH_STOP_MARK
	} phase_t;

	// Duration registers
	logic [irpdt_pkg::TICK_W-1:0] hdr_mark_q;
	logic [irpdt_pkg::TICK_W-1:0] hdr_space_q;
	logic [irpdt_pkg::TICK_W-1:0] bit_mark_q;
	logic [irpdt_pkg::TICK_W-1:0] zero_space_q;
	logic [irpdt_pkg::TICK_W-1:0] one_space_q;
	logic [irpdt_pkg::TICK_W-1:0] stop_mark_q;

	logic [irpdt_pkg::BYTE_W-1:0] buf_q [irpdt_pkg::MAX_FRAME_BYTES];

	phase_t                       phase_q, phase_n;
	logic                         level_q, level_n;
	logic [irpdt_pkg::TICK_W-1:0] tick_q, tick_n;
	logic [irpdt_pkg::CNT_W-1:0]  count_q, count_n;
	logic [irpdt_pkg::PTR_W-1:0]  byte_ptr_q, byte_ptr_n;
	logic [irpdt_pkg::BIT_W-1:0]  bit_ptr_q, bit_ptr_n;
	logic                         out_valid_q;
	irpdt_pkg::out_t              out_data_q;

	logic                         pop;
	logic                         done;
	logic                         rejected;
	logic                         buf_wr;
	logic                         cur_bit;
	logic [irpdt_pkg::BYTE_W-1:0] cur_byte;
	logic [irpdt_pkg::TICK_W-1:0] phase_len;
	logic [irpdt_pkg::TICK_W-1:0] tick_inc;
	logic                         last_in_frame;

	assign pop       = q_valid && (!out_valid_q || out_ready);
	assign q_pop     = pop;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Bit under transmission and length of the current phase
	assign cur_byte = buf_q[byte_ptr_q];
	assign cur_bit  = cur_byte[bit_ptr_q];
	assign tick_inc = tick_q + 1'b1;
	assign last_in_frame =
		(irpdt_pkg::CNT_W'(byte_ptr_q) + irpdt_pkg::CNT_W'(1)) >= count_q;

	always_comb begin
		case (phase_q)
			PH_HDR_MARK:  phase_len = hdr_mark_q;
			PH_HDR_SPACE: phase_len = hdr_space_q;
			PH_BIT_MARK:  phase_len = bit_mark_q;
			PH_BIT_SPACE: phase_len = cur_bit ? one_space_q : zero_space_q;
			PH_STOP_MARK: phase_len = stop_mark_q;
			default:      phase_len = irpdt_pkg::TICK_W'(1);
		endcase
	end

	// Next-state logic for one popped command
	always_comb begin
		phase_n    = phase_q;
		level_n    = level_q;
		tick_n     = tick_q;
		count_n    = count_q;
		byte_ptr_n = byte_ptr_q;
		bit_ptr_n  = bit_ptr_q;
		done       = 1'b0;
		rejected   = 1'b0;
		buf_wr     = 1'b0;
		if (pop) begin
			case (q_op.cmd)
				irpdt_pkg::CMD_LOAD, irpdt_pkg::CMD_LOAD_LAST: begin
					if (phase_q != PH_IDLE) begin
						rejected = 1'b1;
					end else begin
						if (count_q >= irpdt_pkg::CNT_W'(irpdt_pkg::MAX_FRAME_BYTES)) begin
							rejected = 1'b1;
						end else begin
							buf_wr  = 1'b1;
							count_n = count_q + 1'b1;
						end
						if (q_op.cmd == irpdt_pkg::CMD_LOAD_LAST) begin
							byte_ptr_n = '0;
							bit_ptr_n  = '1;
							phase_n    = PH_HDR_MARK;
							level_n    = 1'b0;
							tick_n     = '0;
						end
					end
				end
				irpdt_pkg::CMD_TICK: begin
					if (phase_q != PH_IDLE) begin
						tick_n = tick_inc;
						if (tick_inc >= phase_len) begin
							tick_n = '0;
							case (phase_q)
								PH_HDR_MARK: begin
									phase_n = PH_HDR_SPACE;
									level_n = 1'b1;
								end
								PH_HDR_SPACE: begin
									phase_n = PH_BIT_MARK;
									level_n = 1'b0;
								end
								PH_BIT_MARK: begin
									phase_n = PH_BIT_SPACE;
									level_n = 1'b1;
								end
								PH_BIT_SPACE: begin
									level_n = 1'b0;
									if (bit_ptr_q != '0) begin
										bit_ptr_n = bit_ptr_q - 1'b1;
										phase_n   = PH_BIT_MARK;
									end else if (last_in_frame) begin
										phase_n = PH_STOP_MARK;
									end else begin
										byte_ptr_n = byte_ptr_q + 1'b1;
										bit_ptr_n  = '1;
										phase_n    = PH_BIT_MARK;
									end
								end
								default: begin
									// stop mark finished: back to idle, empty buffer
									phase_n    = PH_IDLE;
									level_n    = 1'b1;
									count_n    = '0;
									byte_ptr_n = '0;
									bit_ptr_n  = '1;
									done       = 1'b1;
								end
							endcase
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Frame buffer
	always_ff @(posedge clk) begin
		if (buf_wr) begin
			buf_q[count_q[irpdt_pkg::PTR_W-1:0]] <= q_op.byte_value;
		end
	end

	// Duration registers, written over the config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_mark_q   <= irpdt_pkg::RST_HDR_MARK;
			hdr_space_q  <= irpdt_pkg::RST_HDR_SPACE;
			bit_mark_q   <= irpdt_pkg::RST_BIT_MARK;
			zero_space_q <= irpdt_pkg::RST_ZERO_SPACE;
			one_space_q  <= irpdt_pkg::RST_ONE_SPACE;
			stop_mark_q  <= irpdt_pkg::RST_STOP_MARK;
		end else if (cfg_wr.valid) begin
			case (cfg_wr.index)
				irpdt_pkg::REG_HDR_MARK:   hdr_mark_q   <= cfg_wr.data;
				irpdt_pkg::REG_HDR_SPACE:  hdr_space_q  <= cfg_wr.data;
				irpdt_pkg::REG_BIT_MARK:   bit_mark_q   <= cfg_wr.data;
				irpdt_pkg::REG_ZERO_SPACE: zero_space_q <= cfg_wr.data;
				irpdt_pkg::REG_ONE_SPACE:  one_space_q  <= cfg_wr.data;
				irpdt_pkg::REG_STOP_MARK:  stop_mark_q  <= cfg_wr.data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			level_q     <= 1'b1;
			tick_q      <= '0;
			count_q     <= '0;
			byte_ptr_q  <= '0;
			bit_ptr_q   <= '1;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			phase_q    <= phase_n;
			level_q    <= level_n;
			tick_q     <= tick_n;
			count_q    <= count_n;
			byte_ptr_q <= byte_ptr_n;
			bit_ptr_q  <= bit_ptr_n;
			if (pop) begin
				out_valid_q              <= 1'b1;
				out_data_q.line_level    <= level_n;
				out_data_q.busy_res      <= (phase_n != PH_IDLE);
				out_data_q.frame_done    <= done;
				out_data_q.load_rejected <= rejected;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/ir_pulse_distance_transmitter.sv
// Each accepted input beat is written into the command queue; the sequencer then
// takes it from the queue and registers its result beat in the output register.
// Throughput: one input beat per cycle, as the sequencer updates on every popped command;
// input stalls only once the two-entry queue and the output register are full.
// Reset (arst_n low, asynchronous): line idle high, sequencer idle, queue and output
// empty, duration registers at defaults; frame buffer contents are not cleared.
module ir_pulse_distance_transmitter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  irpdt_pkg::in_t                       in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output irpdt_pkg::out_t                      out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [irpdt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [irpdt_pkg::TICK_W-1:0]         cfg_data
);

	logic               q_valid;
	logic               q_pop;
	irpdt_pkg::op_t     q_op;
	irpdt_pkg::cfg_wr_t cfg_wr;

	// Config writes are always taken
	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	irpdt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_op     (q_op),
		.q_pop    (q_pop)
	);

	irpdt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
